/* src/dins_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dins_pkg
// shared widths, register codes, control structs and helpers of the
// depth image normal stencil
// ----------------------------------------------------------------------------
package dins_pkg;

   localparam int DEPTH_W        = 16;
   localparam int NORM_W         = 16;
   localparam int NZ_W           = 15;
   localparam int POS_W          = 12;
   localparam int CFG_W          = 13;
   localparam int DIM_W          = 16;
   localparam int APB_DATA_W     = 32;
   localparam int APB_ADDR_W     = 3;
   localparam int LINE_SLOTS     = 5;
   localparam int SLOT_W         = 3;
   localparam int TAP_COUNT      = 9;
   localparam int G_W            = 18;
   localparam int S_W            = 37;
   localparam int GG_W           = 2 * G_W;
   localparam int MAG_W          = 15;
   localparam int TRIAL_W        = 16;
   localparam int TT_W           = 2 * TRIAL_W;
   localparam int PROD_W         = TT_W + S_W;
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int MIN_DIM        = 5;
   localparam int Z_WEIGHT       = 4;

   localparam logic [CFG_W-1:0] DEF_IMAGE_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0] DEF_IMAGE_HEIGHT = CFG_W'(480);

   // register select, byte address bit 2
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic           start;
      logic [G_W-1:0] g;
      logic [S_W-1:0] s;
   } mag_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [MAG_W-1:0] mag;
   } mag_rsp_type;

   // (s + k) mod 5 for line slot numbers
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] k);
      logic [SLOT_W:0] sum;
      sum = {1'b0, s} + {1'b0, k};
      if (sum >= (SLOT_W+1)'(LINE_SLOTS)) begin
         sum = sum - (SLOT_W+1)'(LINE_SLOTS);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* src/dins_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dins channels
// valid/ready channels for depth pixels in and normals out
// ----------------------------------------------------------------------------
interface dins_req_if import dins_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_sample;
   logic               frame_start;

   modport source (output valid, depth_sample, frame_start, input ready);
   modport sink   (input valid, depth_sample, frame_start, output ready);
endinterface

interface dins_rsp_if import dins_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [NORM_W-1:0] normal_x;
   logic signed [NORM_W-1:0] normal_y;
   logic [NZ_W-1:0]          normal_z;
   logic                     has_normal;
   logic [POS_W-1:0]         centre_x;
   logic [POS_W-1:0]         centre_y;
   logic                     frame_last;

   modport source (output valid, normal_x, normal_y, normal_z, has_normal,
                   centre_x, centre_y, frame_last, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, has_normal,
                   centre_x, centre_y, frame_last, output ready);
endinterface
`default_nettype wire

/* src/depth_image_normal_stencil.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// depth_image_normal_stencil
// surface normals from a raster depth stream, five row line store in ram
// ----------------------------------------------------------------------------
// usage
//   req channel: one depth pixel per transfer in raster order, frame_start
//   marks pixel (0,0). rsp channel: one normal per pixel at column >= 2 and
//   row >= 2, for the centre two rows and two columns behind it.
//   apb port: image_width at 0x0, image_height at 0x4, written while idle.
// sequence
//   pixels without a result leave the block idle; a border result goes
//   to the done state and holds the input until the output register takes
//   it. an inner pixel holds the input through the line store reads over
//   the single read port, gradient, squares and sum, then three passes of
//   the bit serial magnitude unit (launch, square, sixteen trials, done)
//   for x, y and z, and the load of the output register; a zero centre
//   depth skips the magnitude passes.
// reset
//   clears the position to (0,0), the registers to 640 x 480 and the
//   handshake state; the line store is not cleared.
// stall
//   results sit in an output register; the next pixel is still taken while
//   it waits, and a finished result holds until the register drains.
// ----------------------------------------------------------------------------
module depth_image_normal_stencil import dins_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dins_req_if.sink                   req,
   dins_rsp_if.source                 rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output logic      [APB_DATA_W-1:0] prdata,
   output logic                       pready
);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int RAM_DEPTH = LINE_SLOTS * MAX_WIDTH;
   localparam int AW        = $clog2(RAM_DEPTH);
   localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] MIND = DIM_W'(MIN_DIM);

   // tap positions in the read shift line
   localparam int TAP_CENTRE = 2;
   localparam int TAP_UP2    = 5;
   localparam int TAP_UP1    = 6;
   localparam int TAP_DN1    = 7;
   localparam int TAP_DN2    = 8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_GRAD, ST_SQUARE, ST_SUM, ST_MAGX, ST_MAGY, ST_MAGZ, ST_DONE
   } state_type;

   // configuration
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             cfg_write;

   // position
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [SLOT_W-1:0] slot_ff;

   // item in flight
   state_type              state_ff;
   logic [COL_W-1:0]       c_ff;
   logic [SLOT_W-1:0]      cur_slot_ff;
   logic [POS_W-1:0]       cx_ff, cy_ff;
   logic                   last_ff;
   logic [3:0]             rd_idx_ff;
   logic [DEPTH_W-1:0]     taps_ff [TAP_COUNT];
   logic [G_W-1:0]         ax_ff, ay_ff;
   logic                   gx_pos_ff, gy_pos_ff;
   logic [GG_W-1:0]        sqx_ff, sqy_ff;
   logic [S_W-1:0]         s_ff;
   logic                   launched_ff;
   logic [NORM_W-1:0]      nx_ff, ny_ff;
   logic [NZ_W-1:0]        nz_ff;
   logic                   has_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [NORM_W-1:0]      rsp_nx_ff, rsp_ny_ff;
   logic [NZ_W-1:0]        rsp_nz_ff;
   logic                   rsp_has_ff;
   logic [POS_W-1:0]       rsp_cx_ff, rsp_cy_ff;
   logic                   rsp_last_ff;

   // combinational
   logic              accept;
   logic [DIM_W-1:0]  w_dim, h_dim, wc, hc;
   logic [DIM_W-1:0]  c0, r0, nc, nr, cx_full, cy_full;
   logic [SLOT_W-1:0] s0, ns;
   logic              emit, inner, frame_last;
   logic [AW-1:0]     waddr, raddr;
   logic [SLOT_W-1:0] rd_slot;
   logic [COL_W-1:0]  rd_col;
   logic [DEPTH_W-1:0] rdata;
   logic signed [G_W:0] gx, gy;
   logic [G_W-1:0]    gx_abs, gy_abs;
   logic              out_load;
   mag_req_type       mag_req;
   mag_rsp_type       mag_rsp;
   logic [NORM_W-1:0] mag_ext;

   function automatic logic [AW-1:0] slot_base(input logic [SLOT_W-1:0] s);
      return AW'(32'(s) * MAX_WIDTH);
   endfunction

   function automatic logic signed [G_W:0] ext(input logic [DEPTH_W-1:0] d);
      return $signed({{(G_W+1-DEPTH_W){1'b0}}, d});
   endfunction

   // apb register file, write on the access phase
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_IMAGE_HEIGHT) ? APB_DATA_W'(height_ff)
                                                      : APB_DATA_W'(width_ff);

   // registers used clamped to the supported frame size
   always_comb begin
      wc    = DIM_W'(width_ff);
      hc    = DIM_W'(height_ff);
      w_dim = (wc < MIND) ? MIND : ((wc > MAXW) ? MAXW : wc);
      h_dim = (hc < MIND) ? MIND : ((hc > MAXH) ? MAXH : hc);
   end

   // position of the incoming pixel and of the one after it
   always_comb begin
      accept = req.valid && req.ready;
      c0 = req.frame_start ? '0 : DIM_W'(col_ff);
      r0 = req.frame_start ? '0 : DIM_W'(row_ff);
      s0 = req.frame_start ? '0 : slot_ff;
      // shrunk width or height wraps the position
      if (c0 >= w_dim) begin
         c0 = '0;
         r0 = r0 + DIM_W'(1);
         s0 = slot_add(s0, SLOT_W'(1));
      end
      if (r0 >= h_dim) begin
         r0 = '0;
         s0 = '0;
      end
      nc = c0 + DIM_W'(1);
      nr = r0;
      ns = s0;
      if (nc >= w_dim) begin
         nc = '0;
         nr = r0 + DIM_W'(1);
         ns = slot_add(s0, SLOT_W'(1));
         if (nr >= h_dim) begin
            nr = '0;
            ns = '0;
         end
      end
      emit       = (c0 >= DIM_W'(2)) && (r0 >= DIM_W'(2));
      inner      = (c0 >= DIM_W'(4)) && (r0 >= DIM_W'(4));
      frame_last = (c0 == w_dim - DIM_W'(1)) && (r0 == h_dim - DIM_W'(1));
      cx_full    = c0 - DIM_W'(2);
      cy_full    = r0 - DIM_W'(2);
      waddr      = slot_base(s0) + AW'(c0);
   end

   // read order: centre row c-4..c, then rows r-4, r-3, r-1, r at column c-2
   always_comb begin
      case (rd_idx_ff)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4: begin
            rd_slot = slot_add(cur_slot_ff, SLOT_W'(3));
            rd_col  = c_ff - COL_W'(4) + COL_W'(rd_idx_ff);
         end
         4'd5: begin
            rd_slot = slot_add(cur_slot_ff, SLOT_W'(1));
            rd_col  = c_ff - COL_W'(2);
         end
         4'd6: begin
            rd_slot = slot_add(cur_slot_ff, SLOT_W'(2));
            rd_col  = c_ff - COL_W'(2);
         end
         4'd7: begin
            rd_slot = slot_add(cur_slot_ff, SLOT_W'(4));
            rd_col  = c_ff - COL_W'(2);
         end
         default: begin
            rd_slot = cur_slot_ff;
            rd_col  = c_ff - COL_W'(2);
         end
      endcase
      raddr = slot_base(rd_slot) + AW'(rd_col);
   end

   dins_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (RAM_DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (accept),
      .waddr (waddr),
      .wdata (req.depth_sample),
      .raddr (raddr),
      .rdata (rdata)
   );

   // gradients, weights two for the near and one for the far neighbour
   always_comb begin
      gx = ((ext(taps_ff[3]) - ext(taps_ff[1])) <<< 1) + (ext(taps_ff[4]) - ext(taps_ff[0]));
      gy = ((ext(taps_ff[TAP_DN1]) - ext(taps_ff[TAP_UP1])) <<< 1)
         + (ext(taps_ff[TAP_DN2]) - ext(taps_ff[TAP_UP2]));
      gx_abs = (gx < 0) ? G_W'(-gx) : G_W'(gx);
      gy_abs = (gy < 0) ? G_W'(-gy) : G_W'(gy);
   end

   // magnitude unit shared by the three components
   always_comb begin
      mag_req.start = ((state_ff == ST_MAGX) || (state_ff == ST_MAGY) ||
                       (state_ff == ST_MAGZ)) && !launched_ff && !mag_rsp.busy;
      mag_req.s     = s_ff;
      case (state_ff)
         ST_MAGX: mag_req.g = ax_ff;
         ST_MAGY: mag_req.g = ay_ff;
         default: mag_req.g = G_W'(Z_WEIGHT);
      endcase
      mag_ext  = NORM_W'(mag_rsp.mag);
      out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   end

   dins_mag u_mag (
      .clock   (clock),
      .reset   (reset),
      .mag_req (mag_req),
      .mag_rsp (mag_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= DEF_IMAGE_WIDTH;
         height_ff    <= DEF_IMAGE_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write) begin
            if (paddr[2] == REG_IMAGE_HEIGHT) begin
               height_ff <= pwdata[CFG_W-1:0];
            end else begin
               width_ff <= pwdata[CFG_W-1:0];
            end
         end

         if (accept) begin
            col_ff  <= nc[COL_W-1:0];
            row_ff  <= nr[ROW_W-1:0];
            slot_ff <= ns;
         end

         // output register drains independently of the work in flight
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_nx_ff    <= nx_ff;
            rsp_ny_ff    <= ny_ff;
            rsp_nz_ff    <= nz_ff;
            rsp_has_ff   <= has_ff;
            rsp_cx_ff    <= cx_ff;
            rsp_cy_ff    <= cy_ff;
            rsp_last_ff  <= last_ff;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (mag_req.start) begin
            launched_ff <= 1'b1;
         end else if (mag_rsp.done) begin
            launched_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  c_ff        <= c0[COL_W-1:0];
                  cur_slot_ff <= s0;
                  cx_ff       <= cx_full[POS_W-1:0];
                  cy_ff       <= cy_full[POS_W-1:0];
                  last_ff     <= frame_last;
                  rd_idx_ff   <= '0;
                  nx_ff       <= '0;
                  ny_ff       <= '0;
                  nz_ff       <= '0;
                  has_ff      <= 1'b0;
                  if (emit && inner) begin
                     state_ff <= ST_READ;
                  end else if (emit) begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_READ: begin
               // read data belongs to the address of the previous cycle
               if (rd_idx_ff != 4'd0) begin
                  for (int j = 0; j < TAP_COUNT - 1; j++) begin
                     taps_ff[j] <= taps_ff[j+1];
                  end
                  taps_ff[TAP_COUNT-1] <= rdata;
               end
               if (rd_idx_ff == 4'(TAP_COUNT)) begin
                  state_ff <= ST_GRAD;
               end else begin
                  rd_idx_ff <= rd_idx_ff + 4'd1;
               end
            end
            ST_GRAD: begin
               ax_ff     <= gx_abs[G_W-1:0];
               ay_ff     <= gy_abs[G_W-1:0];
               gx_pos_ff <= (gx > 0);
               gy_pos_ff <= (gy > 0);
               // zero centre depth gives no normal
               state_ff  <= (taps_ff[TAP_CENTRE] == '0) ? ST_DONE : ST_SQUARE;
            end
            ST_SQUARE: begin
               sqx_ff   <= ax_ff * ax_ff;
               sqy_ff   <= ay_ff * ay_ff;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               s_ff     <= S_W'(sqx_ff) + S_W'(sqy_ff) + S_W'(Z_WEIGHT * Z_WEIGHT);
               state_ff <= ST_MAGX;
            end
            ST_MAGX: begin
               if (mag_rsp.done) begin
                  nx_ff    <= gx_pos_ff ? (NORM_W'(0) - mag_ext) : mag_ext;
                  state_ff <= ST_MAGY;
               end
            end
            ST_MAGY: begin
               if (mag_rsp.done) begin
                  ny_ff    <= gy_pos_ff ? (NORM_W'(0) - mag_ext) : mag_ext;
                  state_ff <= ST_MAGZ;
               end
            end
            ST_MAGZ: begin
               if (mag_rsp.done) begin
                  nz_ff    <= mag_rsp.mag;
                  has_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.normal_x   = $signed(rsp_nx_ff);
   assign rsp.normal_y   = $signed(rsp_ny_ff);
   assign rsp.normal_z   = rsp_nz_ff;
   assign rsp.has_normal = rsp_has_ff;
   assign rsp.centre_x   = rsp_cx_ff;
   assign rsp.centre_y   = rsp_cy_ff;
   assign rsp.frame_last = rsp_last_ff;

   // magnitude unit is only launched while idle
   a_mag_start_idle: assert property (@(posedge clock) disable iff (reset)
      mag_req.start |-> !mag_rsp.busy)
      else $error("magnitude unit launched while busy");

   // frame start restarts the position at the second pixel of row zero
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req.frame_start) |=> (col_ff == COL_W'(1)) && (row_ff == '0))
      else $error("position not restarted by frame start");

   // a result without normal carries zero components
   a_no_normal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.has_normal) |->
         (rsp.normal_x == '0) && (rsp.normal_y == '0) && (rsp.normal_z == '0))
      else $error("non-zero components without normal");

   // line store reads never overlap a magnitude pass
   a_read_mag_exclusive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !mag_rsp.busy)
      else $error("magnitude unit busy during line store reads");
endmodule
`default_nettype wire

/* src/dins_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dins_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dins_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* src/dins_mag.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dins_mag
// bit serial search for round(g * 32768 / sqrt(s)), saturated to 15 bits
// ----------------------------------------------------------------------------
module dins_mag import dins_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mag_req_type mag_req,
   output mag_rsp_type      mag_rsp
);
   typedef enum logic [2:0] {
      M_IDLE, M_SQUARE, M_TRY, M_MUL, M_CMP, M_DONE
   } mag_state_type;

   mag_state_type         state_ff;
   logic [G_W-1:0]        g_ff;
   logic [S_W-1:0]        s_ff;
   logic [GG_W-1:0]       gg_ff;
   logic [TT_W-1:0]       tt_ff;
   logic [63:0]           plo_ff;
   logic [S_W-1:0]        phi_ff;
   logic [TRIAL_W-1:0]    res_ff;
   logic [TRIAL_W-1:0]    trial_ff;
   logic [3:0]            bit_ff;

   logic [TRIAL_W-1:0]    trial_in;
   logic [TRIAL_W:0]      twice;
   logic [TRIAL_W-1:0]    t_odd;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W-1:0]     limit;
   logic                  too_big;

   localparam logic [TRIAL_W-1:0] TRIAL_MAX = TRIAL_W'(32768);
   localparam logic [TRIAL_W-1:0] SAT_MAX   = TRIAL_W'(32767);

   always_comb begin
      trial_in = res_ff | (TRIAL_W'(1) << bit_ff);
      too_big  = trial_in > TRIAL_MAX;
      twice    = {trial_in, 1'b0} - (TRIAL_W+1)'(1);
      t_odd    = twice[TRIAL_W-1:0];
      prod     = {phi_ff, 32'b0} + PROD_W'(plo_ff);
      limit    = {1'b0, gg_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         case (state_ff)
            M_IDLE: begin
               if (mag_req.start) begin
                  g_ff     <= mag_req.g;
                  s_ff     <= mag_req.s;
                  state_ff <= M_SQUARE;
               end
            end
            M_SQUARE: begin
               gg_ff    <= g_ff * g_ff;
               res_ff   <= '0;
               bit_ff   <= 4'd15;
               state_ff <= M_TRY;
            end
            M_TRY: begin
               if (too_big) begin
                  if (bit_ff == 4'd0) begin
                     state_ff <= M_DONE;
                  end else begin
                     bit_ff <= bit_ff - 4'd1;
                  end
               end else begin
                  trial_ff <= trial_in;
                  tt_ff    <= t_odd * t_odd;
                  state_ff <= M_MUL;
               end
            end
            M_MUL: begin
               plo_ff   <= tt_ff * s_ff[31:0];
               phi_ff   <= S_W'(tt_ff * s_ff[S_W-1:32]);
               state_ff <= M_CMP;
            end
            M_CMP: begin
               // (2m-1)^2 * s <= g^2 * 2^32 keeps the trial bit
               if (prod <= limit) begin
                  res_ff <= trial_ff;
               end
               if (bit_ff == 4'd0) begin
                  state_ff <= M_DONE;
               end else begin
                  bit_ff   <= bit_ff - 4'd1;
                  state_ff <= M_TRY;
               end
            end
            M_DONE: begin
               state_ff <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign mag_rsp.busy = (state_ff != M_IDLE);
   assign mag_rsp.done = (state_ff == M_DONE);
   assign mag_rsp.mag  = (res_ff > SAT_MAX) ? SAT_MAX[MAG_W-1:0] : res_ff[MAG_W-1:0];
endmodule
`default_nettype wire

/* bench/depth_image_normal_stencil_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_image_normal_stencil_checker
// watches the register port and both channels, keeps its own line store and
// position, predicts every surface normal and compares it with the output
// ----------------------------------------------------------------------------
module depth_image_normal_stencil_checker import dins_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dins_req_if                        req,
   dins_rsp_if                        rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output int                         error_count,
   output int                         outstanding
);

   typedef struct {
      logic signed [NORM_W-1:0] nx;
      logic signed [NORM_W-1:0] ny;
      logic [NZ_W-1:0]          nz;
      logic                     has;
      logic [POS_W-1:0]         cx;
      logic [POS_W-1:0]         cy;
      logic                     last;
   } normal_type;

   normal_type       expected_normals[$];
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   int               next_col;
   int               next_row;
   logic [DEPTH_W-1:0] row_mem [LINE_SLOTS*DEF_MAX_WIDTH];

   initial error_count = 0;
   assign outstanding = expected_normals.size();

   function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic longint depth_at(int r, int c);
      return longint'(row_mem[(r % LINE_SLOTS) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH)]);
   endfunction

   // round(g * 32768 / sqrt(s)) with ties up, found by bisection on exact squares
   function automatic logic [MAG_W-1:0] unit_magnitude(longint g, longint s);
      logic [127:0] rhs;
      logic [127:0] lhs;
      longint       t;
      int           lo;
      int           hi;
      int           mid;
      rhs = 128'(g) * 128'(g) << 32;
      lo  = 0;
      hi  = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t   = 2 * mid - 1;
         lhs = 128'(t) * 128'(t) * 128'(s);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return (lo > 32767) ? MAG_W'(32767) : MAG_W'(lo);
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s expected %0d got %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      int         w;
      int         h;
      int         c;
      int         r;
      longint     win [5];
      longint     gx;
      longint     gy;
      longint     ax;
      longint     ay;
      longint     s;
      normal_type e;
      normal_type got;
      if (reset) begin
         width_reg  = DEF_IMAGE_WIDTH;
         height_reg = DEF_IMAGE_HEIGHT;
         next_col   = 0;
         next_row   = 0;
         expected_normals.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[2])
               REG_IMAGE_WIDTH:  width_reg  = pwdata[CFG_W-1:0];
               REG_IMAGE_HEIGHT: height_reg = pwdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            w = clamp_dim(width_reg, DEF_MAX_WIDTH);
            h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
            if (req.frame_start) begin
               next_col = 0;
               next_row = 0;
            end
            if (next_col >= w) begin
               next_col = 0;
               next_row++;
            end
            if (next_row >= h) next_row = 0;
            c = next_col;
            r = next_row;
            row_mem[(r % LINE_SLOTS) * DEF_MAX_WIDTH + c] = req.depth_sample;
            if (c >= 2 && r >= 2) begin
               e    = '{default: '0};
               e.cx = POS_W'(c - 2);
               e.cy = POS_W'(r - 2);
               e.last = (c == w - 1) && (r == h - 1);
               for (int k = 0; k < 5; k++) win[k] = depth_at(r - 2, c - 4 + k + DEF_MAX_WIDTH);
               if (c >= 4 && r >= 4 && win[2] != 0) begin
                  gx = 2 * (win[3] - win[1]) + (win[4] - win[0]);
                  gy = 2 * (depth_at(r - 1, c - 2) - depth_at(r - 3, c - 2))
                     + (depth_at(r, c - 2) - depth_at(r - 4, c - 2));
                  ax = gx < 0 ? -gx : gx;
                  ay = gy < 0 ? -gy : gy;
                  s  = ax * ax + ay * ay + 16;
                  e.nx  = unit_magnitude(ax, s);
                  e.ny  = unit_magnitude(ay, s);
                  if (gx > 0) e.nx = -e.nx;
                  if (gy > 0) e.ny = -e.ny;
                  e.nz  = unit_magnitude(Z_WEIGHT, s);
                  e.has = 1'b1;
               end
               expected_normals = {expected_normals, e};
            end
            next_col = c + 1;
            if (next_col >= w) begin
               next_col = 0;
               next_row = r + 1;
               if (next_row >= h) next_row = 0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_normals.size() == 0) begin
               $error("unexpected normal transfer at centre (%0d, %0d)",
                      rsp.centre_x, rsp.centre_y);
               error_count++;
            end else begin
               got = expected_normals.pop_front();
               check_field("normal_x", got.nx, rsp.normal_x);
               check_field("normal_y", got.ny, rsp.normal_y);
               check_field("normal_z", got.nz, rsp.normal_z);
               check_field("has_normal", got.has, rsp.has_normal);
               check_field("centre_x", got.cx, rsp.centre_x);
               check_field("centre_y", got.cy, rsp.centre_y);
               check_field("frame_last", got.last, rsp.frame_last);
            end
         end
      end
   end

endmodule

/* bench/depth_image_normal_stencil_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_image_normal_stencil_test
// drives depth frames of many sizes and textures through the stencil under
// varying idle and stall patterns, with register changes between and within frames;
// the checker beside the block predicts and compares every normal
// ----------------------------------------------------------------------------
module depth_image_normal_stencil_test;
   import dins_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;
   int                    error_count;
   int                    outstanding;

   // idle and stall percentages of the current phase
   int idle_pct;
   int stall_pct;
   int pixels_sent;
   // long receiver hold-off, served by the receiver process
   int hold_asked;
   int hold_served;
   int hold_left;

   dins_req_if req_ch ();
   dins_rsp_if rsp_ch ();

   depth_image_normal_stencil dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   depth_image_normal_stencil_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // hard stop for a hung block
   initial begin
      #40ms;
      $display("depth_image_normal_stencil_test: errors");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off when one is asked for
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_served  <= 0;
      end else if (hold_asked != hold_served) begin
         hold_served  <= hold_asked;
         hold_left    <= 1500;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one pixel transfer; valid stays high between back-to-back pixels
   task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic first);
      if ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.depth_sample <= depth;
      req_ch.frame_start  <= first;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // wait until every expected result, border results included, has left the block
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_size(input int w, input int h);
      drain();
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   // textures: 0 full random, 1 ramp with holes, 2 extremes, 3 flat
   function automatic logic [DEPTH_W-1:0] depth_for(int texture, int c, int r,
                                                    int base, int dx, int dy);
      case (texture)
         0: return DEPTH_W'($urandom);
         1: begin
            if ($urandom_range(15) == 0) return '0;
            return DEPTH_W'(base + dx * c + dy * r + $urandom_range(3));
         end
         2: begin
            case ($urandom_range(3))
               0: return '0;
               1: return 16'hffff;
               default: return DEPTH_W'($urandom);
            endcase
         end
         default: return DEPTH_W'(base);
      endcase
   endfunction

   task automatic send_frame(input int w, input int h, input int count, input int texture);
      int base;
      int dx;
      int dy;
      base = $urandom_range(60000, 1);
      dx   = $urandom_range(200) - 100;
      dy   = $urandom_range(200) - 100;
      for (int i = 0; i < count; i++)
         send_pixel(depth_for(texture, i % w, (i / w) % h, base, dx, dy), i == 0);
   endtask

   logic [DEPTH_W-1:0] directed_frame [25];

   initial begin
      int w;
      int h;
      reset        = 1'b1;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      req_ch.valid = 1'b0;
      req_ch.depth_sample = '0;
      req_ch.frame_start  = 1'b0;
      idle_pct     = 0;
      stall_pct    = 0;
      pixels_sent  = 0;
      hold_asked   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame: one inner centre with large slopes, a flat row
      // and zero depths around it, wrap to (0,0) without frame_start
      directed_frame = '{16'hffff, 16'h0000, 16'h1234, 16'h0000, 16'hffff,
                         16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                         16'h0000, 16'hffff, 16'h4000, 16'h0000, 16'hffff,
                         16'h8000, 16'h8000, 16'h0000, 16'h8000, 16'h8000,
                         16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000};
      write_reg(REG_IMAGE_WIDTH, 5);
      write_reg(REG_IMAGE_HEIGHT, 5);
      for (int i = 0; i < 25; i++) send_pixel(directed_frame[i], i == 0);
      // a flat frame follows straight on, no frame_start at its first pixel
      for (int i = 0; i < 25; i++) send_pixel(16'h2000, 1'b0);
      // a partial flat frame, then frame_start in mid-frame for a frame of extremes
      send_frame(5, 5, 12, 3);
      send_frame(5, 5, 25, 2);

      // clamped register values and the extremes of the frame shape
      set_size(0, 8191);
      send_frame(5, 4096, 5 * 6, 1);
      set_size(8191, 3);
      send_frame(4096, 5, 20, 0);
      set_size(4096, 4096);
      send_frame(4096, 4096, 20, 2);

      // width shrinks in mid-frame: position wraps to the next row
      set_size(8, 8);
      send_frame(8, 8, 64 + 31, 0);
      set_size(6, 8);
      for (int i = 0; i < 20; i++) send_pixel(DEPTH_W'($urandom), 1'b0);

      // random frames over idling phases
      for (int phase = 0; phase < 5 || pixels_sent < 600; phase++) begin
         case (phase % 5)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            3: begin idle_pct = 13; stall_pct = 13; end
            default: begin idle_pct = $urandom_range(30); stall_pct = $urandom_range(30); end
         endcase
         w = $urandom_range(12, 5);
         h = $urandom_range(9, 5);
         set_size(w, h);
         if (phase == 2) begin
            // long hold-off while pixels keep coming: block must back up
            hold_asked++;
            send_frame(w, h, w * h, 0);
         end else if (phase == 3) begin
            // sender waits for every normal before going on
            send_frame(w, h, w * h / 2, 1);
            drain();
            send_frame(w, h, w * h, 1);
         end else begin
            send_frame(w, h, w * h * $urandom_range(2, 1), $urandom_range(3));
         end
      end

      idle_pct  = 0;
      stall_pct = 0;
      drain();
      if (error_count == 0) begin
         $display("depth_image_normal_stencil_test: clean");
      end else begin
         $display("depth_image_normal_stencil_test: errors");
      end
      $finish;
   end

endmodule

/* sim.f */
src/dins_pkg.sv
src/dins_if.sv
src/dins_ram.sv
src/dins_mag.sv
src/depth_image_normal_stencil.sv
bench/depth_image_normal_stencil_checker.sv
bench/depth_image_normal_stencil_test.sv
